@@ design/slc_pkg.sv @@
// slc_pkg: shared types, constants and register codes of the time-slice
// length calculator. Used by the interfaces and by every design module.
package slc_pkg;

   localparam int NUM_STAGES = 9;

   localparam int QUANTUM_W = 20;
   localparam int MULT_W    = 5;
   localparam int THRESH_W  = 10;
   localparam int RECIP_W   = 16;
   localparam int LOAD_W    = 11;
   localparam int THREADS_W = 12;
   localparam int CPUS_W    = 7;
   localparam int SCORE_W   = 10;
   localparam int SLICE_W   = 24;
   localparam int CSR_IDX_W = 3;

   localparam logic [QUANTUM_W-1:0] MIN_GRANULARITY = 20'd1200;
   localparam logic [10:0]          LOAD_SCALE      = 11'd1024;
   localparam logic [10:0]          SCORE_BIAS      = 11'd1500;
   localparam logic [10:0]          SCORE_RECIP     = 11'd1049;
   localparam logic [SCORE_W-1:0]   SCORE_MAX       = 10'd1000;
   localparam logic [SLICE_W-1:0]   SLICE_MAX       = 24'hFFFFFF;

   localparam logic [QUANTUM_W-1:0] BASE_SLICE_RST      = 20'd2000;
   localparam logic [QUANTUM_W-1:0] MIN_SLICE_RST       = 20'd500;
   localparam logic [QUANTUM_W-1:0] LATENCY_CAP_RST     = 20'd3200;
   localparam logic [MULT_W-1:0]    MEDIUM_MULT_RST     = 5'd2;
   localparam logic [THRESH_W-1:0]  LOW_THRESH_RST      = 10'd200;
   localparam logic [RECIP_W-1:0]   LOAD_RECIP_RST      = 16'd1311;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_SLICE      = 3'd0,
      CSR_MIN_SLICE       = 3'd1,
      CSR_LATENCY_CAP     = 3'd2,
      CSR_MEDIUM_MULT     = 3'd3,
      CSR_LOW_THRESH      = 3'd4,
      CSR_LOAD_RECIP      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [QUANTUM_W-1:0] base_slice;
      logic [QUANTUM_W-1:0] min_slice;
      logic [QUANTUM_W-1:0] latency_cap;
      logic [MULT_W-1:0]    medium_multiplier;
      logic [THRESH_W-1:0]  low_load_threshold;
      logic [RECIP_W-1:0]   load_range_reciprocal;
   } cfg_type;

   typedef struct packed {
      logic                 real_time;
      logic [QUANTUM_W-1:0] thread_own_slice;
      logic                 core_usable;
      logic [LOAD_W-1:0]    core_load;
      logic [THREADS_W-1:0] thread_count;
      logic [CPUS_W-1:0]    cpu_count;
      logic                 display_ready;
      logic [SCORE_W-1:0]   interactivity;
   } req_payload_type;

   // per-item fields that ride along the whole pipe
   typedef struct packed {
      logic                 rt;
      logic                 usable;
      logic                 disp;
      logic [QUANTUM_W-1:0] own;
      logic [QUANTUM_W-1:0] dispq;
   } ctx_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctrl_type;

endpackage

@@ design/slc_if.sv @@
// slc_if: valid/ready channel interfaces for request and response beats.
// Depends on slc_pkg for field widths.
interface slc_req_if;
   logic                               valid;
   logic                               ready;
   logic                               real_time;
   logic [slc_pkg::QUANTUM_W-1:0]      thread_own_slice;
   logic                               core_usable;
   logic [slc_pkg::LOAD_W-1:0]         core_load;
   logic [slc_pkg::THREADS_W-1:0]      thread_count;
   logic [slc_pkg::CPUS_W-1:0]         cpu_count;
   logic                               display_ready;
   logic [slc_pkg::SCORE_W-1:0]        interactivity;

   modport source (
      output valid, real_time, thread_own_slice, core_usable, core_load,
             thread_count, cpu_count, display_ready, interactivity,
      input  ready
   );
   modport sink (
      input  valid, real_time, thread_own_slice, core_usable, core_load,
             thread_count, cpu_count, display_ready, interactivity,
      output ready
   );
endinterface

interface slc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [slc_pkg::SLICE_W-1:0]   slice_length;

   modport source (output valid, slice_length, input ready);
   modport sink (input valid, slice_length, output ready);
endinterface

@@ design/slc_csr_regs.sv @@
// slc_csr_regs: configuration register file, written through a plain write port.
// Depends on slc_pkg for the register codes, reset values and cfg_type.
module slc_csr_regs (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [slc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [slc_pkg::QUANTUM_W-1:0]   csr_wdata,
   output slc_pkg::cfg_type                cfg
);

   slc_pkg::cfg_type cfg_ff;
   slc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (slc_pkg::csr_index_type'(csr_index))
            slc_pkg::CSR_BASE_SLICE:  cfg_in.base_slice = csr_wdata;
            slc_pkg::CSR_MIN_SLICE:   cfg_in.min_slice = csr_wdata;
            slc_pkg::CSR_LATENCY_CAP: cfg_in.latency_cap = csr_wdata;
            slc_pkg::CSR_MEDIUM_MULT: begin
               cfg_in.medium_multiplier = csr_wdata[slc_pkg::MULT_W-1:0];
            end
            slc_pkg::CSR_LOW_THRESH: begin
               cfg_in.low_load_threshold = csr_wdata[slc_pkg::THRESH_W-1:0];
            end
            slc_pkg::CSR_LOAD_RECIP: begin
               cfg_in.load_range_reciprocal = csr_wdata[slc_pkg::RECIP_W-1:0];
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_slice            <= slc_pkg::BASE_SLICE_RST;
         cfg_ff.min_slice             <= slc_pkg::MIN_SLICE_RST;
         cfg_ff.latency_cap           <= slc_pkg::LATENCY_CAP_RST;
         cfg_ff.medium_multiplier     <= slc_pkg::MEDIUM_MULT_RST;
         cfg_ff.low_load_threshold    <= slc_pkg::LOW_THRESH_RST;
         cfg_ff.load_range_reciprocal <= slc_pkg::LOAD_RECIP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/slc_pipe_ctrl.sv @@
// slc_pipe_ctrl: stage valid bits and per-stage load enables of the pipeline.
// Depends on slc_pkg for the stage count and pipe_ctrl_type.
module slc_pipe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output slc_pkg::pipe_ctrl_type ctrl
);

   logic [slc_pkg::NUM_STAGES-1:0] valid_ff;
   logic [slc_pkg::NUM_STAGES-1:0] valid_in;
   logic [slc_pkg::NUM_STAGES-1:0] advance;

   // a stage moves when it is empty or the stage after it moves
   always_comb begin
      advance[slc_pkg::NUM_STAGES-1] = !valid_ff[slc_pkg::NUM_STAGES-1] || out_ready;
      for (int i = slc_pkg::NUM_STAGES - 2; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (advance[0]) begin
         valid_in[0] = in_valid;
      end
      for (int i = 1; i < slc_pkg::NUM_STAGES; i++) begin
         if (advance[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.load = advance;
   assign in_ready  = advance[0];
   assign out_valid = valid_ff[slc_pkg::NUM_STAGES-1];

endmodule

@@ design/slc_datapath.sv @@
// slc_datapath: nine-stage arithmetic of the slice length, one stage per enable.
// Depends on slc_pkg for types and constants; enables come from slc_pipe_ctrl.
module slc_datapath (
   input  logic                           clock,
   input  slc_pkg::pipe_ctrl_type         ctrl,
   input  slc_pkg::cfg_type               cfg,
   input  slc_pkg::req_payload_type       req,
   output logic [slc_pkg::SLICE_W-1:0]    slice_length
);

   slc_pkg::ctx_type ctx_ff [slc_pkg::NUM_STAGES-1];
   slc_pkg::ctx_type ctx_in;

   // stage 1: flags, load difference, score clamp
   logic        gt1_ff, gt1_in;
   logic [10:0] diff1_ff, diff1_in;
   logic        cont1_ff, cont1_in, over1_ff, over1_in;
   logic [9:0]  score1_ff, score1_in;
   logic [19:0] high1_ff, high1_in;
   // stage 2: medium quantum
   logic        gt2_ff, cont2_ff, over2_ff;
   logic [10:0] diff2_ff;
   logic [9:0]  score2_ff;
   logic [19:0] high2_ff;
   logic [24:0] med2_ff, med2_in;
   // stage 3: floor and ceiling, raw load ratio
   logic        gt3_ff;
   logic [24:0] floor3_ff, floor3_in, ceil3_ff, ceil3_in;
   logic [26:0] raw3_ff, raw3_in;
   logic [10:0] fb3_ff, fb3_in;
   // stage 4: inverse ratio, span, interactivity factor
   logic               gt4_ff;
   logic [24:0]        floor4_ff, ceil4_ff;
   logic [10:0]        inv4_ff, inv4_in;
   logic signed [25:0] delta4_ff, delta4_in;
   logic [20:0]        fac4_ff, fac4_in;
   logic [21:0]        fac_prod;
   logic [16:0]        ratio;
   // stage 5: inverse squared
   logic               gt5_ff;
   logic [24:0]        floor5_ff, ceil5_ff;
   logic [20:0]        invsq5_ff, invsq5_in;
   logic [21:0]        invsq_prod;
   logic signed [25:0] delta5_ff;
   logic [20:0]        fac5_ff;
   // stage 6: bend product
   logic               gt6_ff;
   logic [24:0]        floor6_ff, ceil6_ff;
   logic signed [47:0] bend6_ff, bend6_in;
   logic [20:0]        fac6_ff;
   // stage 7: bent quantum
   logic [24:0]        floor7_ff, ceil7_ff;
   logic [24:0]        q7_ff, q7_in;
   logic signed [47:0] bend_sh;
   logic signed [27:0] q_sum;
   logic [20:0]        fac7_ff;
   // stage 8: interactivity scaling
   logic [24:0]        floor8_ff, ceil8_ff;
   logic [45:0]        scaled8_ff, scaled8_in;
   // stage 9: clamps and result select
   logic [23:0]        slice9_ff, slice9_in;
   logic [25:0]        scaled_sh, lo_ext, clamp_lo, clamp_hi;
   logic [24:0]        lo_q;

   // ---- stage 1
   always_comb begin
      ctx_in.rt     = req.real_time;
      ctx_in.usable = req.core_usable;
      ctx_in.disp   = req.display_ready;
      ctx_in.own    = req.thread_own_slice;
      ctx_in.dispq  = (cfg.min_slice > slc_pkg::MIN_GRANULARITY)
                    ? cfg.min_slice : slc_pkg::MIN_GRANULARITY;
      high1_in  = (cfg.base_slice > slc_pkg::MIN_GRANULARITY)
                ? cfg.base_slice : slc_pkg::MIN_GRANULARITY;
      gt1_in    = req.core_load > {1'b0, cfg.low_load_threshold};
      diff1_in  = req.core_load - {1'b0, cfg.low_load_threshold};
      cont1_in  = req.thread_count > {5'd0, req.cpu_count};
      over1_in  = req.thread_count > {4'd0, req.cpu_count, 1'b0};
      score1_in = (req.interactivity > slc_pkg::SCORE_MAX)
                ? slc_pkg::SCORE_MAX : req.interactivity;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         gt1_ff    <= gt1_in;
         diff1_ff  <= diff1_in;
         cont1_ff  <= cont1_in;
         over1_ff  <= over1_in;
         score1_ff <= score1_in;
         high1_ff  <= high1_in;
      end
   end

   // context rides along with its item
   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         ctx_ff[0] <= ctx_in;
      end
      for (int i = 1; i < slc_pkg::NUM_STAGES - 1; i++) begin
         if (ctrl.load[i]) begin
            ctx_ff[i] <= ctx_ff[i-1];
         end
      end
   end

   // ---- stage 2
   assign med2_in = cfg.base_slice * cfg.medium_multiplier;

   always_ff @(posedge clock) begin
      if (ctrl.load[1]) begin
         gt2_ff    <= gt1_ff;
         diff2_ff  <= diff1_ff;
         cont2_ff  <= cont1_ff;
         over2_ff  <= over1_ff;
         score2_ff <= score1_ff;
         high2_ff  <= high1_ff;
         med2_ff   <= med2_in;
      end
   end

   // ---- stage 3
   always_comb begin
      floor3_in = med2_ff;
      ceil3_in  = {5'd0, cfg.latency_cap};
      if (ctx_ff[1].disp) begin
         floor3_in = {5'd0, ctx_ff[1].dispq};
         ceil3_in  = {5'd0, ctx_ff[1].dispq};
      end else if (over2_ff) begin
         floor3_in = {5'd0, high2_ff};
         ceil3_in  = {5'd0, high2_ff};
      end else if (cont2_ff) begin
         floor3_in = {5'd0, high2_ff};
         ceil3_in  = med2_ff;
      end
      raw3_in = diff2_ff * cfg.load_range_reciprocal;
      fb3_in  = slc_pkg::SCORE_BIAS - {1'b0, score2_ff};
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[2]) begin
         gt3_ff    <= gt2_ff;
         floor3_ff <= floor3_in;
         ceil3_ff  <= ceil3_in;
         raw3_ff   <= raw3_in;
         fb3_ff    <= fb3_in;
      end
   end

   // ---- stage 4
   always_comb begin
      ratio     = raw3_ff[26:10];
      inv4_in   = (ratio > {6'd0, slc_pkg::LOAD_SCALE})
                ? 11'd0 : slc_pkg::LOAD_SCALE - ratio[10:0];
      delta4_in = $signed({1'b0, ceil3_ff}) - $signed({1'b0, floor3_ff});
      fac_prod  = fb3_ff * slc_pkg::SCORE_RECIP;
      fac4_in   = fac_prod[20:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[3]) begin
         gt4_ff    <= gt3_ff;
         floor4_ff <= floor3_ff;
         ceil4_ff  <= ceil3_ff;
         inv4_ff   <= inv4_in;
         delta4_ff <= delta4_in;
         fac4_ff   <= fac4_in;
      end
   end

   // ---- stage 5
   always_comb begin
      invsq_prod = inv4_ff * inv4_ff;
      invsq5_in  = invsq_prod[20:0];
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[4]) begin
         gt5_ff    <= gt4_ff;
         floor5_ff <= floor4_ff;
         ceil5_ff  <= ceil4_ff;
         invsq5_ff <= invsq5_in;
         delta5_ff <= delta4_ff;
         fac5_ff   <= fac4_ff;
      end
   end

   // ---- stage 6
   assign bend6_in = delta5_ff * $signed({1'b0, invsq5_ff});

   always_ff @(posedge clock) begin
      if (ctrl.load[5]) begin
         gt6_ff    <= gt5_ff;
         floor6_ff <= floor5_ff;
         ceil6_ff  <= ceil5_ff;
         bend6_ff  <= bend6_in;
         fac6_ff   <= fac5_ff;
      end
   end

   // ---- stage 7: floor shift keeps the bent value between floor and ceiling
   always_comb begin
      bend_sh = bend6_ff >>> 20;
      q_sum   = $signed({3'd0, floor6_ff}) + bend_sh[27:0];
      q7_in   = gt6_ff ? q_sum[24:0] : ceil6_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[6]) begin
         floor7_ff <= floor6_ff;
         ceil7_ff  <= ceil6_ff;
         q7_ff     <= q7_in;
         fac7_ff   <= fac6_ff;
      end
   end

   // ---- stage 8
   assign scaled8_in = q7_ff * fac7_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load[7]) begin
         floor8_ff  <= floor7_ff;
         ceil8_ff   <= ceil7_ff;
         scaled8_ff <= scaled8_in;
      end
   end

   // ---- stage 9
   always_comb begin
      scaled_sh = scaled8_ff[45:20];
      lo_q      = ctx_ff[7].disp ? floor8_ff : {5'd0, slc_pkg::MIN_GRANULARITY};
      lo_ext    = {1'b0, lo_q};
      clamp_lo  = (scaled_sh > lo_ext) ? scaled_sh : lo_ext;
      clamp_hi  = (clamp_lo > {1'b0, ceil8_ff}) ? {1'b0, ceil8_ff} : clamp_lo;
      if (ctx_ff[7].rt) begin
         slice9_in = {4'd0, ctx_ff[7].own};
      end else if (!ctx_ff[7].usable) begin
         slice9_in = {4'd0, ctx_ff[7].dispq};
      end else if (clamp_hi > {2'd0, slc_pkg::SLICE_MAX}) begin
         slice9_in = slc_pkg::SLICE_MAX;
      end else begin
         slice9_in = clamp_hi[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[8]) begin
         slice9_ff <= slice9_in;
      end
   end

   assign slice_length = slice9_ff;

endmodule

@@ design/time_slice_length_calc_top.sv @@
// time_slice_length_calc_top: thread time-slice length calculator.
// Each accepted request beat passes through stages 1 to 9 in order; the
// 9-stage pipeline holds up to 9 items. Throughput: one beat per cycle if
// the response is taken; a stall halts only the full stages up to a bubble.
// Reset (synchronous, active high) empties the pipeline and loads the
// configuration registers with their defaults.
module time_slice_length_calc_top (
   input  logic                            clock,
   input  logic                            reset,
   slc_req_if.sink                         req_bus,
   slc_rsp_if.source                       rsp_bus,
   input  logic                            csr_write_en,
   input  logic [slc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [slc_pkg::QUANTUM_W-1:0]   csr_wdata
);

   slc_pkg::cfg_type          cfg;
   slc_pkg::pipe_ctrl_type    ctrl;
   slc_pkg::req_payload_type  req_payload;

   always_comb begin
      req_payload.real_time           = req_bus.real_time;
      req_payload.thread_own_slice    = req_bus.thread_own_slice;
      req_payload.core_usable         = req_bus.core_usable;
      req_payload.core_load           = req_bus.core_load;
      req_payload.thread_count        = req_bus.thread_count;
      req_payload.cpu_count           = req_bus.cpu_count;
      req_payload.display_ready       = req_bus.display_ready;
      req_payload.interactivity       = req_bus.interactivity;
   end

   slc_csr_regs u_csr_regs (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   slc_pipe_ctrl u_pipe_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .ctrl      (ctrl)
   );

   slc_datapath u_datapath (
      .clock        (clock),
      .ctrl         (ctrl),
      .cfg          (cfg),
      .req          (req_payload),
      .slice_length (rsp_bus.slice_length)
   );

endmodule
